// ===== sv/eic_pkg.sv =====
// Shared types, codes and ROM helper for the eased interpolation core.
`timescale 1ns / 1ps

package eic_pkg;

    // Binary point of the mantissa used to build the log table.
    localparam int unsigned MANT_POINT = 31;

    typedef enum logic [1:0] {
        CURVE_LINEAR  = 2'd0,
        CURVE_LOG_IN  = 2'd1,
        CURVE_LOG_OUT = 2'd2,
        CURVE_INVALID = 2'd3
    } curve_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_ZERO_SPAN = 2'd1,
        ERR_BAD_CURVE = 2'd2
    } err_t;

    typedef struct packed {
        logic signed [15:0] span_start;
        logic signed [15:0] position;
        logic signed [15:0] span_end;
        logic signed [15:0] from_value;
        logic signed [15:0] to_value;
        curve_t             curve;
    } item_t;

    typedef struct packed {
        logic signed [15:0] value;
        err_t               error;
    } result_t;

    // Per-item data that rides alongside the fraction through the pipe.
    typedef struct packed {
        logic signed [15:0] from_value;
        logic        [15:0] amount_mag;
        logic               amount_neg;
        logic               use_log;
        err_t               err;
    } side_t;

    // log2 of a Q1.31 mantissa in [1, 2), one truncated bit per squaring.
    function automatic logic [63:0] log2_frac(input logic [63:0] x_init,
                                              input int unsigned frac_bits);
        logic [63:0] x;
        logic [63:0] acc;
        x   = x_init;
        acc = '0;
        for (int unsigned b = 0; b < frac_bits; b++) begin
            x   = (x * x) >> MANT_POINT;
            acc = acc << 1;
            if (x >= (64'd1 << (MANT_POINT + 1))) begin
                acc = acc | 64'd1;
                x   = x >> 1;
            end
        end
        return acc;
    endfunction

endpackage

// ===== sv/eic_prep.sv =====
// Front stages: error check, span ordering, clamp and distance terms.
`timescale 1ns / 1ps

module eic_prep (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  eic_pkg::item_t     item,
    output logic               span_valid,
    input  logic               span_ready,
    output logic        [15:0] num,
    output logic        [15:0] den,
    output eic_pkg::side_t     span_side
);

    logic               s1_valid_reg;
    logic signed [15:0] s1_start_reg;
    logic signed [15:0] s1_pos_reg;
    logic signed [15:0] s1_lo_reg;
    logic signed [15:0] s1_hi_reg;
    logic        [15:0] s1_den_reg;
    eic_pkg::side_t     s1_side_reg;

    logic               s2_valid_reg;
    logic        [15:0] s2_num_reg;
    logic        [15:0] s2_den_reg;
    eic_pkg::side_t     s2_side_reg;

    logic               s1_ready;
    logic               s2_ready;

    logic               ascending;
    logic        [16:0] span_diff;
    logic        [16:0] amount_diff;
    logic signed [15:0] s1_lo_next;
    logic signed [15:0] s1_hi_next;
    logic        [15:0] s1_den_next;
    eic_pkg::side_t     s1_side_next;

    logic signed [15:0] clamped;
    logic        [16:0] pos_diff;
    logic        [15:0] s2_num_next;

    assign s2_ready   = !s2_valid_reg || span_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign item_ready = s1_ready;

    always_comb
    begin
        ascending   = item.span_start < item.span_end;
        span_diff   = {item.span_end[15], item.span_end}
                    - {item.span_start[15], item.span_start};
        amount_diff = {item.to_value[15], item.to_value}
                    - {item.from_value[15], item.from_value};
        s1_lo_next  = ascending ? item.span_start : item.span_end;
        s1_hi_next  = ascending ? item.span_end : item.span_start;
        s1_den_next = span_diff[16] ? 16'(-span_diff) : span_diff[15:0];

        s1_side_next.from_value = item.from_value;
        s1_side_next.amount_mag = amount_diff[16] ? 16'(-amount_diff) : amount_diff[15:0];
        s1_side_next.amount_neg = amount_diff[16];
        s1_side_next.use_log    = item.curve != eic_pkg::CURVE_LINEAR;
        priority if (item.curve == eic_pkg::CURVE_INVALID)
        begin
            s1_side_next.err = eic_pkg::ERR_BAD_CURVE;
        end
        else if (item.span_start == item.span_end)
        begin
            s1_side_next.err = eic_pkg::ERR_ZERO_SPAN;
        end
        else
        begin
            s1_side_next.err = eic_pkg::ERR_NONE;
        end
    end

    always_comb
    begin
        priority if (s1_pos_reg < s1_lo_reg)
        begin
            clamped = s1_lo_reg;
        end
        else if (s1_pos_reg > s1_hi_reg)
        begin
            clamped = s1_hi_reg;
        end
        else
        begin
            clamped = s1_pos_reg;
        end
        pos_diff    = {clamped[15], clamped} - {s1_start_reg[15], s1_start_reg};
        s2_num_next = pos_diff[16] ? 16'(-pos_diff) : pos_diff[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_start_reg <= item.span_start;
            s1_pos_reg   <= item.position;
            s1_lo_reg    <= s1_lo_next;
            s1_hi_reg    <= s1_hi_next;
            s1_den_reg   <= s1_den_next;
            s1_side_reg  <= s1_side_next;
        end
        if (s2_ready)
        begin
            s2_num_reg  <= s2_num_next;
            s2_den_reg  <= s1_den_reg;
            s2_side_reg <= s1_side_reg;
        end
    end

    assign span_valid = s2_valid_reg;
    assign num        = s2_num_reg;
    assign den        = s2_den_reg;
    assign span_side  = s2_side_reg;

endmodule

// ===== sv/eic_divider.sv =====
// Restoring divider, one quotient bit per pipeline stage.
`timescale 1ns / 1ps

module eic_divider #(
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  span_valid,
    output logic                  span_ready,
    input  logic           [15:0] num,
    input  logic           [15:0] den,
    input  eic_pkg::side_t        span_side,
    output logic                  frac_valid,
    input  logic                  frac_ready,
    output logic [VALUE_BITS:0]   frac,
    output eic_pkg::side_t        frac_side
);

    localparam int unsigned QB = VALUE_BITS + 1;
    localparam logic [VALUE_BITS:0] ONE = (VALUE_BITS + 1)'(1) << VALUE_BITS;

    logic                valid_reg [QB];
    logic         [15:0] rem_reg   [QB];
    logic         [15:0] den_reg   [QB];
    logic [VALUE_BITS:0] quot_reg  [QB];
    eic_pkg::side_t      side_reg  [QB];
    logic       [QB:0]   ready;

    assign ready[QB]  = frac_ready;
    assign span_ready = ready[0];

    for (genvar j = 0; j < QB; j++)
    begin : g_stage
        logic         [15:0] rem_in;
        logic         [15:0] den_in;
        logic [VALUE_BITS:0] quot_in;
        eic_pkg::side_t      side_in;
        logic                valid_in;
        logic         [16:0] trial;
        logic                take;
        logic         [15:0] rem_next;
        logic [VALUE_BITS:0] quot_next;

        if (j == 0)
        begin : g_first
            assign rem_in   = num;
            assign den_in   = den;
            assign quot_in  = '0;
            assign side_in  = span_side;
            assign valid_in = span_valid;
        end
        else
        begin : g_later
            assign rem_in   = rem_reg[j-1];
            assign den_in   = den_reg[j-1];
            assign quot_in  = quot_reg[j-1];
            assign side_in  = side_reg[j-1];
            assign valid_in = valid_reg[j-1];
        end

        // First stage decides the integer bit; later ones shift the remainder.
        assign trial     = (j == 0) ? {1'b0, rem_in} : {rem_in, 1'b0};
        assign take      = trial >= {1'b0, den_in};
        assign rem_next  = take ? 16'(trial - {1'b0, den_in}) : trial[15:0];
        assign quot_next = {quot_in[VALUE_BITS-1:0], take};
        assign ready[j]  = !valid_reg[j] || ready[j+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (ready[j])
            begin
                valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ready[j])
            begin
                rem_reg[j]  <= rem_next;
                den_reg[j]  <= den_in;
                quot_reg[j] <= quot_next;
                side_reg[j] <= side_in;
            end
        end
    end

    assign frac_valid = valid_reg[QB-1];
    assign frac       = quot_reg[QB-1];
    assign frac_side  = side_reg[QB-1];

    assert property (@(posedge clk) disable iff (!rst_n)
        frac_valid && frac_side.err == eic_pkg::ERR_NONE |-> frac <= ONE)
        else $error("fraction above one on a valid span");

endmodule

// ===== sv/eic_log_map.sv =====
// Curve stage: passes the fraction or maps it through the log2(1+p) table.
`timescale 1ns / 1ps

module eic_log_map #(
    parameter int unsigned VALUE_BITS      = 16,
    parameter int unsigned LOG_TABLE_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                frac_valid,
    output logic                frac_ready,
    input  logic [VALUE_BITS:0] frac,
    input  eic_pkg::side_t      frac_side,
    output logic                weight_valid,
    input  logic                weight_ready,
    output logic [VALUE_BITS:0] weight,
    output eic_pkg::side_t      weight_side
);

    localparam int unsigned VB = VALUE_BITS;
    localparam int unsigned IW = $clog2(LOG_TABLE_DEPTH);
    localparam int unsigned RW = $clog2(LOG_TABLE_DEPTH + 1);
    localparam int unsigned SW = VB + IW;
    localparam int unsigned PW = 2 * VB + 1;
    localparam logic [VB:0] ONE = (VB + 1)'(1) << VB;

    logic [VB:0] rom [LOG_TABLE_DEPTH + 1];

    for (genvar i = 0; i < LOG_TABLE_DEPTH; i++)
    begin : g_rom
        localparam logic [63:0] MANT = (64'd1 << eic_pkg::MANT_POINT)
                                     + ((64'(i) << eic_pkg::MANT_POINT) / LOG_TABLE_DEPTH);
        localparam logic [63:0] ENTRY = eic_pkg::log2_frac(MANT, VALUE_BITS);
        assign rom[i] = ENTRY[VB:0];
    end
    assign rom[LOG_TABLE_DEPTH] = ONE;

    logic           l1_valid_reg;
    logic [IW-1:0]  l1_idx_reg;
    logic [VB-1:0]  l1_rem_reg;
    logic [VB:0]    l1_frac_reg;
    eic_pkg::side_t l1_side_reg;

    logic           l2_valid_reg;
    logic [VB:0]    l2_lo_reg;
    logic [VB:0]    l2_step_reg;
    logic [VB-1:0]  l2_rem_reg;
    logic [VB:0]    l2_frac_reg;
    eic_pkg::side_t l2_side_reg;

    logic           l3_valid_reg;
    logic [VB:0]    l3_weight_reg;
    eic_pkg::side_t l3_side_reg;

    logic           l1_ready;
    logic           l2_ready;
    logic           l3_ready;

    logic [SW-1:0]  scaled;
    logic [RW-1:0]  addr_lo;
    logic [RW-1:0]  addr_hi;
    logic [VB:0]    l2_step_next;
    logic [PW-1:0]  interp;
    logic [VB:0]    l3_weight_next;

    assign l3_ready   = !l3_valid_reg || weight_ready;
    assign l2_ready   = !l2_valid_reg || l3_ready;
    assign l1_ready   = !l1_valid_reg || l2_ready;
    assign frac_ready = l1_ready;

    assign scaled  = SW'(frac[VB-1:0]) * SW'(LOG_TABLE_DEPTH);
    assign addr_lo = RW'(l1_idx_reg);
    assign addr_hi = addr_lo + RW'(1);
    assign l2_step_next = rom[addr_hi] - rom[addr_lo];
    assign interp = PW'(l2_step_reg) * PW'(l2_rem_reg);

    always_comb
    begin
        priority if (!l2_side_reg.use_log)
        begin
            l3_weight_next = l2_frac_reg;
        end
        else if (l2_frac_reg[VB])
        begin
            l3_weight_next = ONE;
        end
        else
        begin
            l3_weight_next = l2_lo_reg + interp[PW-1:VB];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_valid_reg <= 1'b0;
            l2_valid_reg <= 1'b0;
            l3_valid_reg <= 1'b0;
        end
        else
        begin
            if (l1_ready)
            begin
                l1_valid_reg <= frac_valid;
            end
            if (l2_ready)
            begin
                l2_valid_reg <= l1_valid_reg;
            end
            if (l3_ready)
            begin
                l3_valid_reg <= l2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (l1_ready)
        begin
            l1_idx_reg  <= scaled[SW-1:VB];
            l1_rem_reg  <= scaled[VB-1:0];
            l1_frac_reg <= frac;
            l1_side_reg <= frac_side;
        end
        if (l2_ready)
        begin
            l2_lo_reg   <= rom[addr_lo];
            l2_step_reg <= l2_step_next;
            l2_rem_reg  <= l1_rem_reg;
            l2_frac_reg <= l1_frac_reg;
            l2_side_reg <= l1_side_reg;
        end
        if (l3_ready)
        begin
            l3_weight_reg <= l3_weight_next;
            l3_side_reg   <= l2_side_reg;
        end
    end

    assign weight_valid = l3_valid_reg;
    assign weight       = l3_weight_reg;
    assign weight_side  = l3_side_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        weight_valid && weight_side.err == eic_pkg::ERR_NONE |-> weight <= ONE)
        else $error("curve weight above one on a valid span");

endmodule

// ===== sv/eic_scale.sv =====
// Back stages: scale the value delta by the weight and form the result.
`timescale 1ns / 1ps

module eic_scale #(
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                weight_valid,
    output logic                weight_ready,
    input  logic [VALUE_BITS:0] weight,
    input  eic_pkg::side_t      weight_side,
    output logic                result_valid,
    input  logic                result_ready,
    output eic_pkg::result_t    result
);

    localparam int unsigned VB = VALUE_BITS;
    localparam int unsigned PW = 16 + VB + 1;

    logic             m1_valid_reg;
    logic [PW-1:0]    m1_prod_reg;
    eic_pkg::side_t   m1_side_reg;

    logic             m2_valid_reg;
    eic_pkg::result_t m2_result_reg;

    logic             m1_ready;
    logic             m2_ready;

    logic [PW-1:0]    m1_prod_next;
    logic [15:0]      delta;
    logic [16:0]      base;
    logic [16:0]      sum;
    eic_pkg::result_t m2_result_next;

    assign m2_ready     = !m2_valid_reg || result_ready;
    assign m1_ready     = !m1_valid_reg || m2_ready;
    assign weight_ready = m1_ready;

    assign m1_prod_next = PW'(weight_side.amount_mag) * PW'(weight);

    always_comb
    begin
        // Weight is at most one, so the shifted product fits the magnitude.
        delta = m1_prod_reg[VB+15:VB];
        base  = {m1_side_reg.from_value[15], m1_side_reg.from_value};
        sum   = m1_side_reg.amount_neg ? base - {1'b0, delta} : base + {1'b0, delta};
        m2_result_next.error = m1_side_reg.err;
        if (m1_side_reg.err == eic_pkg::ERR_NONE)
        begin
            m2_result_next.value = sum[15:0];
        end
        else
        begin
            m2_result_next.value = m1_side_reg.from_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end
        else
        begin
            if (m1_ready)
            begin
                m1_valid_reg <= weight_valid;
            end
            if (m2_ready)
            begin
                m2_valid_reg <= m1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (m1_ready)
        begin
            m1_prod_reg <= m1_prod_next;
            m1_side_reg <= weight_side;
        end
        if (m2_ready)
        begin
            m2_result_reg <= m2_result_next;
        end
    end

    assign result_valid = m2_valid_reg;
    assign result       = m2_result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        m1_valid_reg && m1_side_reg.err == eic_pkg::ERR_NONE
        |-> m1_prod_reg[PW-1:VB] <= (PW - VB)'(m1_side_reg.amount_mag))
        else $error("scaled delta exceeds value span");

endmodule

// ===== sv/eased_interpolation_core.sv =====
// Top level of the eased interpolation core.
// Takes one item per clock while the result side does not stall and returns
// one result per item, in order: two front stages clamp the position and
// form the distances, a restoring divider produces the Q1.VALUE_BITS
// fraction one quotient bit per stage (VALUE_BITS + 1 stages, which sets the
// latency), three stages apply the linear or log2(1+p) curve through an
// interpolated constant table, and two stages scale the value delta and
// register the result. Every stage holds its own valid bit, so a stalled
// result only backs up the stages behind it and empty stages keep filling.
// An invalid curve code or a zero-length span is flagged in the error field
// and returns the start value.
`timescale 1ns / 1ps

module eased_interpolation_core #(
    parameter int unsigned VALUE_BITS      = 16,
    parameter int unsigned LOG_TABLE_DEPTH = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  eic_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output eic_pkg::result_t result
);

    logic                item_ready;
    logic                span_valid;
    logic                span_ready;
    logic         [15:0] num;
    logic         [15:0] den;
    eic_pkg::side_t      span_side;
    logic                frac_valid;
    logic                frac_ready;
    logic [VALUE_BITS:0] frac;
    eic_pkg::side_t      frac_side;
    logic                weight_valid;
    logic                weight_ready;
    logic [VALUE_BITS:0] weight;
    eic_pkg::side_t      weight_side;

    assign item_stall = !item_ready;

    eic_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .num        (num),
        .den        (den),
        .span_side  (span_side)
    );

    eic_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .num        (num),
        .den        (den),
        .span_side  (span_side),
        .frac_valid (frac_valid),
        .frac_ready (frac_ready),
        .frac       (frac),
        .frac_side  (frac_side)
    );

    eic_log_map #(
        .VALUE_BITS      (VALUE_BITS),
        .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
    ) u_log_map (
        .clk          (clk),
        .rst_n        (rst_n),
        .frac_valid   (frac_valid),
        .frac_ready   (frac_ready),
        .frac         (frac),
        .frac_side    (frac_side),
        .weight_valid (weight_valid),
        .weight_ready (weight_ready),
        .weight       (weight),
        .weight_side  (weight_side)
    );

    eic_scale #(
        .VALUE_BITS (VALUE_BITS)
    ) u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .weight_valid (weight_valid),
        .weight_ready (weight_ready),
        .weight       (weight),
        .weight_side  (weight_side),
        .result_valid (result_valid),
        .result_ready (!result_stall),
        .result       (result)
    );

endmodule
